// ===== design/mean_abs_relative_clipper_assert.svh =====
// Assertion macros for the mean-absolute-relative clipper checker.
// Included by the checker file; no other dependencies.
`ifndef MEAN_ABS_RELATIVE_CLIPPER_ASSERT_SVH
`define MEAN_ABS_RELATIVE_CLIPPER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define MRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define MRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset.
`define MRC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mrc_pkg.sv =====
// Shared widths, types and constants for the mean-absolute-relative clipper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mrc_pkg;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned COUNT_W     = 20;
   localparam int unsigned CNT_W       = COUNT_W + 1;          // holds 2^COUNT_W itself
   localparam int unsigned SUM_W       = SAMPLE_W + COUNT_W;
   localparam int unsigned MEAN_W      = SAMPLE_W;             // mean <= 2^(SAMPLE_W-1)
   localparam int unsigned LIMIT_W     = SAMPLE_W;
   localparam int unsigned FACTOR_W    = 16;
   localparam int unsigned FACTOR_FRAC = 8;
   localparam int unsigned PROD_W      = MEAN_W + FACTOR_W;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned STEP_W      = $clog2(SUM_W + 1);

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(256);
   localparam logic [LIMIT_W-1:0]  LIMIT_OPEN   = LIMIT_W'(1) << (SAMPLE_W - 1);
   localparam logic [LIMIT_W-1:0]  LIMIT_MAX    = LIMIT_OPEN - LIMIT_W'(1);

   typedef enum logic {
      KIND_ACCUM = 1'b0,
      KIND_CLIP  = 1'b1
   } mrc_kind_type;

   typedef struct packed {
      mrc_kind_type               kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0]        mag;
   } mrc_item_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [CNT_W-1:0]   divisor;
   } mrc_div_req_type;

   typedef struct packed {
      logic               done;
      logic [MEAN_W-1:0]  quotient;
   } mrc_div_rsp_type;

endpackage

// ===== design/mean_abs_relative_clipper.sv =====
// Clip items pass the queue, then the rsp result register; accumulate items give no result.
// Throughput: one item per cycle (one back end step per queue head) while rsp is not stalled.
// The first clip item of a frame waits for the limit: start of the bit-serial sum/count divider,
// its run and done flag, one multiply, one saturate; an empty frame sets the open limit instead.
// Reset (synchronous, active high): sum, count, limit and phase cleared, factor set
// to 1.0 (256), queue emptied, no result pending.
`timescale 1ns / 1ps

// Top level: front end classifies incoming items and pushes them into a short
// queue; the back end drains the queue, keeps the frame statistics, derives the
// clip limit once per frame and clamps clip items into its output register.
module mean_abs_relative_clipper
   import mrc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration: clip factor, unsigned Q8.8
   input  logic                 csr_wr_en,
   input  logic [FACTOR_W-1:0]  csr_wr_data,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample (signed)
   input  logic                 req_tuser,   // [0] action: 0 accumulate, 1 clip
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,   // [15:0] value (signed)
   output logic                 rsp_tuser    // [0] was_clipped
);

   // front -> queue
   logic          push;
   mrc_item_type  push_item;
   logic          queue_full;

   // queue -> back
   logic          head_valid;
   mrc_item_type  head;
   logic          pop;

   mrc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Decouples acceptance from the back end, so input keeps flowing while the
   // back end waits on the output or on the divider (until the queue fills).
   mrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Holds clip factor, sum, count, limit and phase; result register at rsp.
   mrc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== design/mrc_front.sv =====
// Front end: takes input items, classifies them and computes |sample|.
// Depends on mrc_pkg; feeds mrc_queue.
`timescale 1ns / 1ps

module mrc_front
   import mrc_pkg::*;
(
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,
   input  logic                 req_tuser,
   input  logic                 queue_full,
   output logic                 push,
   output mrc_item_type         push_item
);

   logic signed [SAMPLE_W-1:0] sample;

   assign sample     = signed'(req_tdata);
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.sample = sample;
      push_item.mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(~req_tdata + 1'b1) : req_tdata;
      unique case (req_tuser)
         1'b0:    push_item.kind = KIND_ACCUM;
         default: push_item.kind = KIND_CLIP;
      endcase
   end

endmodule

// ===== design/mrc_queue.sv =====
// Short item queue between front and back end.
// Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_queue
   import mrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mrc_item_type  push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output mrc_item_type  head
);

   mrc_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                do_pop;

   assign full       = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/mrc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle (abs sum / count).
// Depends on mrc_pkg; used by mrc_back.
`timescale 1ns / 1ps

module mrc_div
   import mrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mrc_div_req_type  div_req,
   output mrc_div_rsp_type  div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    dvd_ff, dvd_in;     // dividend shifts out, quotient shifts in
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    dsr_ff, dsr_in;
   logic [CNT_W:0]      rem_shift;
   logic [CNT_W:0]      rem_diff;
   logic                fits;

   assign rem_shift = {rem_ff, dvd_ff[SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};
   assign fits      = (rem_shift >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits CNT_W bits
         rem_in  = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         dvd_in  = {dvd_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   // mean never exceeds 2^(SAMPLE_W-1), so the low bits carry the whole quotient
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff[MEAN_W-1:0];

endmodule

// ===== design/mrc_back.sv =====
// Back end: frame state, limit computation and clamping, output register.
// Depends on mrc_pkg and mrc_div; drains mrc_queue.
`timescale 1ns / 1ps

module mrc_back
   import mrc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [FACTOR_W-1:0]  csr_wr_data,
   input  logic                 head_valid,
   input  mrc_item_type         head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,
   output logic                 rsp_tuser
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_MUL,
      ST_SAT
   } state_type;

   state_type               state_ff, state_in;
   logic [FACTOR_W-1:0]     factor_ff, factor_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;
   logic                    phase_ff, phase_in;
   logic [MEAN_W-1:0]       mean_ff, mean_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                    rsp_clip_ff, rsp_clip_in;

   mrc_div_req_type         div_req;
   mrc_div_rsp_type         div_rsp;

   logic                    out_free;
   logic signed [SAMPLE_W:0] samp_ext;
   logic signed [SAMPLE_W:0] lim_pos;
   logic signed [SAMPLE_W:0] lim_neg;
   logic [PROD_W-FACTOR_FRAC-1:0] scaled;

   mrc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign samp_ext = {head.sample[SAMPLE_W-1], head.sample};
   assign lim_pos  = signed'({1'b0, limit_ff});
   assign lim_neg  = -lim_pos;
   assign scaled   = prod_ff[PROD_W-1:FACTOR_FRAC];

   always_comb begin
      state_in     = state_ff;
      factor_in    = csr_wr_en ? csr_wr_data : factor_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      phase_in     = phase_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_clip_in  = rsp_clip_ff;
      pop          = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = sum_ff;
      div_req.divisor  = count_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (head_valid) begin
               unique case (head.kind)
                  KIND_ACCUM: begin
                     pop = 1'b1;
                     if (phase_ff) begin
                        // new frame: restart the sum with this sample
                        phase_in = 1'b0;
                        sum_in   = SUM_W'(head.mag);
                        count_in = CNT_W'(1);
                     end else if (!count_ff[CNT_W-1]) begin
                        sum_in   = sum_ff + SUM_W'(head.mag);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                     if (phase_ff) begin
                        if (out_free) begin
                           pop          = 1'b1;
                           rsp_valid_in = 1'b1;
                           rsp_clip_in  = 1'b0;
                           rsp_value_in = head.sample;
                           if (samp_ext > lim_pos) begin
                              rsp_value_in = lim_pos[SAMPLE_W-1:0];
                              rsp_clip_in  = 1'b1;
                           end else if (samp_ext < lim_neg) begin
                              rsp_value_in = lim_neg[SAMPLE_W-1:0];
                              rsp_clip_in  = 1'b1;
                           end
                        end
                     end else if (count_ff == '0) begin
                        // empty frame: a limit no sample can exceed
                        limit_in = LIMIT_OPEN;
                        phase_in = 1'b1;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mean_ff) * PROD_W'(factor_ff);
            state_in = ST_SAT;
         end
         default: begin
            limit_in = (scaled > (PROD_W-FACTOR_FRAC)'(LIMIT_MAX)) ? LIMIT_MAX
                                                                  : scaled[LIMIT_W-1:0];
            phase_in = 1'b1;
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         factor_ff    <= FACTOR_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         limit_ff     <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff      <= mean_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_clip_ff;

endmodule

// ===== design/mrc_checker.sv =====
// Port-level checks for mean_abs_relative_clipper, attached by bind.
// Depends on mrc_pkg and mean_abs_relative_clipper_assert.svh.
`timescale 1ns / 1ps
`include "mean_abs_relative_clipper_assert.svh"

module mrc_checker
   import mrc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [SAMPLE_W-1:0]  rsp_tdata,
   input logic                 rsp_tuser
);

   // a stalled item stays offered
   `MRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp item dropped while stalled")

   // a stalled item keeps its payload
   `MRC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed while stalled")

   // a clipped value sits at +/- an enforced limit, which never reaches the most negative code
   `MRC_ASSERT_NOW(a_clip_range, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata != LIMIT_OPEN, "clipped value outside limit range")

   // reset leaves no result pending and the queue ready
   `MRC_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind mean_abs_relative_clipper mrc_checker u_mrc_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for mean_abs_relative_clipper: directed and framed random items,
// checked against a built-in predictor under random stalls on both streams.
// Depends on mrc_pkg and the block RTL only.
`timescale 1ns / 1ps

module tb;
   import mrc_pkg::*;

   localparam int unsigned FULL_COUNT = 1 << COUNT_W;
   localparam int unsigned RANDOM_ITEMS = 450;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [FACTOR_W-1:0] csr_wr_data = FACTOR_RESET;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;    // [15:0] sample (signed)
   logic                req_tuser = 1'b0;  // [0] action: 0 accumulate, 1 clip
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;         // [15:0] value (signed)
   logic                rsp_tuser;         // [0] was_clipped

   // Mirror of the frame statistics and the clip limit; holds the clamped
   // values still owed by the block, oldest first.
   class clip_tracker;
      typedef struct packed {
         logic [SAMPLE_W-1:0] value;
         logic                was_clipped;
      } clip_result_type;

      logic [FACTOR_W-1:0] factor;
      longint unsigned     abs_sum;
      longint unsigned     sample_count;
      longint              clip_limit;
      bit                  clipping;
      clip_result_type     expected_clips[$];
      int unsigned         errors;

      function new();
         factor       = FACTOR_RESET;
         abs_sum      = 0;
         sample_count = 0;
         clip_limit   = 0;
         clipping     = 1'b0;
         errors       = 0;
      endfunction

      function void set_factor(logic [FACTOR_W-1:0] value);
         factor = value;
      endfunction

      function int unsigned pending();
         return expected_clips.size();
      endfunction

      function void note_item(mrc_kind_type kind, logic [SAMPLE_W-1:0] sample);
         longint          s;
         longint          v;
         clip_result_type r;
         s = longint'(signed'(sample));
         if (kind == KIND_ACCUM) begin
            // accumulate after clipping opens a new frame
            if (clipping) begin
               abs_sum      = 0;
               sample_count = 0;
               clipping     = 1'b0;
            end
            // once the count is full, further samples are dropped
            if (sample_count < FULL_COUNT) begin
               abs_sum += (s < 0) ? -s : s;
               sample_count++;
            end
         end else begin
            if (!clipping) begin
               // empty frame: limit above any sample, so nothing clips
               if (sample_count == 0) begin
                  clip_limit = LIMIT_OPEN;
               end else begin
                  clip_limit = ((abs_sum / sample_count) * factor) >> FACTOR_FRAC;
                  if (clip_limit > LIMIT_MAX) clip_limit = LIMIT_MAX;
               end
               clipping = 1'b1;
            end
            v = s;
            r.was_clipped = 1'b0;
            if (v > clip_limit) begin
               v = clip_limit;
               r.was_clipped = 1'b1;
            end
            if (v < -clip_limit) begin
               v = -clip_limit;
               r.was_clipped = 1'b1;
            end
            r.value = SAMPLE_W'(v);
            expected_clips.insert(expected_clips.size(), r);
         end
      endfunction

      task report_mismatch(string what);
         if (errors < 100) $display("tb: mismatch: %s", what);
         errors++;
      endtask

      task check_result(logic [SAMPLE_W-1:0] value, logic was_clipped);
         clip_result_type want;
         if (expected_clips.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d clipped=%0b",
                                      $signed(value), was_clipped));
            return;
         end
         want = expected_clips.pop_front();
         if (value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d",
                                      $signed(value), $signed(want.value)));
         if (was_clipped !== want.was_clipped)
            report_mismatch($sformatf("was_clipped %0b, want %0b (value %0d)",
                                      was_clipped, want.was_clipped, $signed(want.value)));
      endtask
   endclass

   clip_tracker board = new();
   bit          steady = 1'b0;   // sender runs back to back while set

   mean_abs_relative_clipper u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Monitor: both handshakes are sampled at the edge that completes them.
   // Inputs are noted first; a clip item cannot answer in the same cycle anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_item(mrc_kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Result back-pressure: ready runs broken by stalls; long open runs now and then.
   initial begin
      int unsigned run;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         run = idle_gap();
         if (run != 0) begin
            rsp_tready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   // One item on the request stream. Valid stays high when no gap follows;
   // the caller either sends again right away or drains, which drops it.
   task automatic send_item(mrc_kind_type kind, int sample);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= SAMPLE_W'(sample);
      do @(posedge clock); while (req_tready !== 1'b1);
      gap = steady ? 0 : idle_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every clamped value is back, then let accumulate items
   // still queued inside the block settle. Polled on the falling edge so the
   // monitor is done with the rising one.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
      @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_factor(logic [FACTOR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_factor(value);
   endtask

   // Stimulus
   initial begin
      int unsigned sent;
      int unsigned scale;
      int unsigned n_acc;
      int unsigned n_clip;
      longint      est;
      int          s;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // empty frame straight after reset: clipping is off
      send_item(KIND_CLIP, 32767);
      send_item(KIND_CLIP, -32768);
      send_item(KIND_CLIP, 0);
      // mean 200 at factor 1.0: edges of the limit
      send_item(KIND_ACCUM, 100);
      send_item(KIND_ACCUM, -300);
      send_item(KIND_CLIP, 200);
      send_item(KIND_CLIP, 201);
      send_item(KIND_CLIP, -201);
      send_item(KIND_CLIP, -200);
      // mean 32768: limit saturates, most negative sample is clamped and flagged
      send_item(KIND_ACCUM, -32768);
      send_item(KIND_ACCUM, -32768);
      send_item(KIND_CLIP, -32768);
      send_item(KIND_CLIP, 32767);
      // factor zero: limit zero
      write_factor('0);
      send_item(KIND_ACCUM, 1234);
      send_item(KIND_CLIP, 1);
      send_item(KIND_CLIP, -1);
      send_item(KIND_CLIP, 0);
      // largest factor: small mean scaled up, then saturated through the product
      write_factor('1);
      send_item(KIND_ACCUM, 1);
      send_item(KIND_CLIP, 255);
      send_item(KIND_CLIP, -256);
      send_item(KIND_ACCUM, 200);
      send_item(KIND_CLIP, -32768);
      send_item(KIND_CLIP, 32767);

      // --- random frames ---
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
               0:       write_factor('0);
               1:       write_factor('1);
               2:       write_factor(FACTOR_RESET);
               3:       write_factor(FACTOR_W'($urandom_range(64, 1024)));
               default: write_factor(FACTOR_W'($urandom()));
            endcase
         end
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0:       scale = 32767;
            1:       scale = 4095;
            2:       scale = 255;
            default: scale = 15;
         endcase
         // rough limit, only to aim clip samples near the boundary
         est = ((scale / 2) * longint'(board.factor)) >> FACTOR_FRAC;
         if (est > LIMIT_MAX) est = LIMIT_MAX;
         n_acc  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         n_clip = $urandom_range(0, 10);
         repeat (n_acc) begin
            if ($urandom_range(0, 11) == 0) begin
               send_item(mrc_kind_type'($urandom_range(0, 1)), int'($urandom()));
            end else begin
               if ($urandom_range(0, 31) == 0) s = $urandom_range(0, 1) ? -32768 : 32767;
               else s = $urandom_range(0, 1) ? -int'($urandom_range(0, scale))
                                             : int'($urandom_range(0, scale));
               send_item(KIND_ACCUM, s);
            end
            sent++;
         end
         repeat (n_clip) begin
            if ($urandom_range(0, 3) == 0) s = int'($urandom());
            else s = int'(est) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) s = -s;
            send_item(KIND_CLIP, s);
            sent++;
         end
      end

      drain();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: well above the worst case of about 0.3 ms for this item count
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== mean_abs_relative_clipper.f =====
+incdir+design
design/mrc_pkg.sv
design/mrc_front.sv
design/mrc_queue.sv
design/mrc_div.sv
design/mrc_back.sv
design/mean_abs_relative_clipper.sv
design/mrc_checker.sv
dv/tb.sv
